@@ sv/gzhp_pkg.sv @@
// ----------------------------------------------------------------------------
// gzhp_pkg
// Shared types, constants and helpers for the gzip member header parser.
// ----------------------------------------------------------------------------
package gzhp_pkg;

	// Parse phase. The numeric value of a phase is also the byte class that
	// a byte consumed in that phase carries on the output.
	typedef enum logic [2:0] {
		PH_FIXED   = 3'd0,
		PH_XLEN    = 3'd1,
		PH_XDATA   = 3'd2,
		PH_NAME    = 3'd3,
		PH_COMMENT = 3'd4,
		PH_HCRC    = 3'd5,
		PH_DONE    = 3'd6
	} phase_t;

	typedef enum logic [2:0] {
		ST_BUSY     = 3'd0,
		ST_OK       = 3'd1,
		ST_NOT_GZIP = 3'd2,
		ST_METHOD   = 3'd3,
		ST_CRC_BAD  = 3'd4
	} status_t;

	localparam logic [7:0]  MagicFirst    = 8'h1f;
	localparam logic [7:0]  MagicSecond   = 8'h8b;
	localparam logic [7:0]  MethodDeflate = 8'd8;
	localparam logic [3:0]  FixedLen      = 4'd10;
	localparam logic [31:0] CrcPreset     = 32'hffff_ffff;
	localparam logic [31:0] CrcPoly       = 32'hedb8_8320;

	// Bit positions inside the FLG byte.
	localparam int FlgHcrcBit    = 1;
	localparam int FlgExtraBit   = 2;
	localparam int FlgNameBit    = 3;
	localparam int FlgCommentBit = 4;

	// Field positions inside the fixed ten-byte header.
	localparam logic [3:0] PosMagic1 = 4'd0;
	localparam logic [3:0] PosMagic2 = 4'd1;
	localparam logic [3:0] PosMethod = 4'd2;
	localparam logic [3:0] PosFlags  = 4'd3;
	localparam logic [3:0] PosTimeHi = 4'd7;
	localparam logic [3:0] PosXfl    = 4'd8;

	// One result transaction.
	typedef struct packed {
		logic [2:0]  byte_class;
		logic [7:0]  payload_byte;
		logic [2:0]  status;
		logic [7:0]  header_flags;
		logic [31:0] mod_time;
		logic [7:0]  extra_flags;
		logic [7:0]  os_code;
		logic [15:0] running_crc;
	} result_t;

	// Next optional section that follows section 'from', or PH_DONE when the
	// header ends there.
	function automatic phase_t next_section(input phase_t from, input logic [7:0] flags);
		phase_t nxt;
		if (from < PH_XLEN && flags[FlgExtraBit]) begin
			nxt = PH_XLEN;
		end else if (from < PH_NAME && flags[FlgNameBit]) begin
			nxt = PH_NAME;
		end else if (from < PH_COMMENT && flags[FlgCommentBit]) begin
			nxt = PH_COMMENT;
		end else if (from < PH_HCRC && flags[FlgHcrcBit]) begin
			nxt = PH_HCRC;
		end else begin
			nxt = PH_DONE;
		end
		return nxt;
	endfunction

endpackage

@@ sv/gzip_header_parser_core.sv @@
// ----------------------------------------------------------------------------
// gzip_header_parser_core
// gzip member header parser: checks magic and method, captures the fixed
// header fields, skips the extra field, tags name and comment bytes and
// checks the optional header CRC against a running CRC-32.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+---------------------------------------
//  input    | in_valid / in_ready  | stream_byte, restart
//  output   | out_valid / out_ready| byte_class, payload_byte, status,
//           |                      | header_flags, mod_time, extra_flags,
//           |                      | os_code, running_crc
//
//  Every input transaction yields exactly one output transaction.
//  The byte is registered on accept, parsed from the input register (state
//  machine plus one byte-wide CRC-32 step), and the result is registered
//  for the output. Sustained rate is one byte per cycle while out_ready is high.
//  Reset (arst_n low) returns the parser to the start of a header with the
//  CRC preset to all ones; a byte flagged with restart does the same first.
//  An output stall holds the result register; the input stage still takes
//  one more byte, and in_ready drops only when both stages are full.
//
module gzip_header_parser_core (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  stream_byte,
	input  logic        restart,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  byte_class,
	output logic [7:0]  payload_byte,
	output logic [2:0]  status,
	output logic [7:0]  header_flags,
	output logic [31:0] mod_time,
	output logic [7:0]  extra_flags,
	output logic [7:0]  os_code,
	output logic [15:0] running_crc
);

	// Input stage.
	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              restart_s1;

	// Result stage.
	logic              valid_s2;
	gzhp_pkg::result_t result_s2;

	gzhp_pkg::result_t parse_result;
	logic              adv_s2;
	logic              step;
	logic              in_xfer;

	// The result stage can load when it is empty or is being drained.
	assign adv_s2   = !valid_s2 || out_ready;
	assign step     = valid_s1 && adv_s2;
	assign in_ready = !valid_s1 || adv_s2;
	assign in_xfer  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_s1    <= stream_byte;
			restart_s1 <= restart;
		end
	end

	// The parser state advances exactly when a byte moves into the result stage.
	gzhp_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.byte_in    (byte_s1),
		.restart_in (restart_s1),
		.result     (parse_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_s2 <= parse_result;
		end
	end

	assign out_valid    = valid_s2;
	assign byte_class   = result_s2.byte_class;
	assign payload_byte = result_s2.payload_byte;
	assign status       = result_s2.status;
	assign header_flags = result_s2.header_flags;
	assign mod_time     = result_s2.mod_time;
	assign extra_flags  = result_s2.extra_flags;
	assign os_code      = result_s2.os_code;
	assign running_crc  = result_s2.running_crc;

	// A parsed byte always shows up in the result stage on the next cycle.
	a_step_lands: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> valid_s2)
		else $error("parsed byte lost before result stage");

	// Bytes past the header only appear once a final status is set.
	a_not_header_status: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && result_s2.byte_class == 3'(gzhp_pkg::PH_DONE))
			|-> result_s2.status != 3'(gzhp_pkg::ST_BUSY))
		else $error("non-header byte while still busy");

	// Both stages full means the input side must be held off.
	a_full_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !out_ready) |-> !in_ready)
		else $error("input accepted with both stages full");

endmodule

@@ sv/gzhp_crc.sv @@
// ----------------------------------------------------------------------------
// gzhp_crc
// Reflected CRC-32 update for one data byte (polynomial 0xEDB88320).
// ----------------------------------------------------------------------------
module gzhp_crc (
	input  logic [31:0] crc_in,
	input  logic [7:0]  data,
	output logic [31:0] crc_out
);

	always_comb begin
		logic [31:0] c;
		c = crc_in ^ {24'd0, data};
		for (int i = 0; i < 8; i++) begin
			c = (c >> 1) ^ (gzhp_pkg::CrcPoly & {32{c[0]}});
		end
		crc_out = c;
	end

endmodule

@@ sv/gzhp_parser.sv @@
// ----------------------------------------------------------------------------
// gzhp_parser
// Header state machine, captured fields and CRC register. Consumes one byte
// per step and presents the result of that byte combinationally.
// ----------------------------------------------------------------------------
module gzhp_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          byte_in,
	input  logic                restart_in,
	output gzhp_pkg::result_t   result
);

	gzhp_pkg::phase_t  phase_q, base_phase, phase_d;
	gzhp_pkg::status_t status_q, base_status, status_d;
	logic [3:0]  count_q, base_count, count_d;
	logic [7:0]  flags_q, base_flags, flags_d;
	logic [31:0] time_q, base_time, time_d;
	logic [7:0]  xfl_q, base_xfl, xfl_d;
	logic [7:0]  os_q, base_os, os_d;
	logic [15:0] xleft_q, base_xleft, xleft_d;
	logic [31:0] crc_q, base_crc, crc_d, crc_upd;
	logic [7:0]  crc_lo_q, base_crc_lo, crc_lo_d;
	logic [3:0]  count_inc;
	logic [15:0] xleft_dec;
	logic [15:0] xlen_full;

	// A restart byte is parsed against freshly reset state.
	always_comb begin
		if (restart_in) begin
			base_phase  = gzhp_pkg::PH_FIXED;
			base_status = gzhp_pkg::ST_BUSY;
			base_count  = 4'd0;
			base_flags  = 8'd0;
			base_time   = 32'd0;
			base_xfl    = 8'd0;
			base_os     = 8'd0;
			base_xleft  = 16'd0;
			base_crc    = gzhp_pkg::CrcPreset;
			base_crc_lo = 8'd0;
		end else begin
			base_phase  = phase_q;
			base_status = status_q;
			base_count  = count_q;
			base_flags  = flags_q;
			base_time   = time_q;
			base_xfl    = xfl_q;
			base_os     = os_q;
			base_xleft  = xleft_q;
			base_crc    = crc_q;
			base_crc_lo = crc_lo_q;
		end
	end

	gzhp_crc u_crc (
		.crc_in  (base_crc),
		.data    (byte_in),
		.crc_out (crc_upd)
	);

	assign count_inc = base_count + 4'd1;
	assign xleft_dec = base_xleft - 16'd1;
	assign xlen_full = base_xleft | {byte_in, 8'd0};

	// Next state.
	always_comb begin
		phase_d  = base_phase;
		status_d = base_status;
		count_d  = base_count;
		flags_d  = base_flags;
		time_d   = base_time;
		xfl_d    = base_xfl;
		os_d     = base_os;
		xleft_d  = base_xleft;
		crc_lo_d = base_crc_lo;
		crc_d    = (base_phase <= gzhp_pkg::PH_COMMENT) ? crc_upd : base_crc;

		unique case (base_phase)
			gzhp_pkg::PH_FIXED: begin
				if (base_count == gzhp_pkg::PosMagic1 && byte_in != gzhp_pkg::MagicFirst) begin
					phase_d  = gzhp_pkg::PH_DONE;
					status_d = gzhp_pkg::ST_NOT_GZIP;
				end else if (base_count == gzhp_pkg::PosMagic2
						&& byte_in != gzhp_pkg::MagicSecond) begin
					phase_d  = gzhp_pkg::PH_DONE;
					status_d = gzhp_pkg::ST_NOT_GZIP;
				end else if (base_count == gzhp_pkg::PosMethod
						&& byte_in != gzhp_pkg::MethodDeflate) begin
					phase_d  = gzhp_pkg::PH_DONE;
					status_d = gzhp_pkg::ST_METHOD;
				end else begin
					if (base_count == gzhp_pkg::PosFlags) begin
						flags_d = byte_in;
					end else if (base_count > gzhp_pkg::PosFlags
							&& base_count <= gzhp_pkg::PosTimeHi) begin
						time_d = base_time | ({24'd0, byte_in} << {base_count[1:0], 3'b000});
					end else if (base_count == gzhp_pkg::PosXfl) begin
						xfl_d = byte_in;
					end else if (base_count > gzhp_pkg::PosXfl) begin
						os_d = byte_in;
					end
					count_d = count_inc;
					if (count_inc >= gzhp_pkg::FixedLen) begin
						count_d = 4'd0;
						phase_d = gzhp_pkg::next_section(gzhp_pkg::PH_FIXED, base_flags);
					end
				end
			end
			gzhp_pkg::PH_XLEN: begin
				if (base_count == 4'd0) begin
					xleft_d = {8'd0, byte_in};
					count_d = 4'd1;
				end else begin
					xleft_d = xlen_full;
					count_d = 4'd0;
					if (xlen_full == 16'd0) begin
						phase_d = gzhp_pkg::next_section(gzhp_pkg::PH_XDATA, base_flags);
					end else begin
						phase_d = gzhp_pkg::PH_XDATA;
					end
				end
			end
			gzhp_pkg::PH_XDATA: begin
				xleft_d = xleft_dec;
				if (xleft_dec == 16'd0) begin
					count_d = 4'd0;
					phase_d = gzhp_pkg::next_section(gzhp_pkg::PH_XDATA, base_flags);
				end
			end
			gzhp_pkg::PH_NAME: begin
				if (byte_in == 8'd0) begin
					count_d = 4'd0;
					phase_d = gzhp_pkg::next_section(gzhp_pkg::PH_NAME, base_flags);
				end
			end
			gzhp_pkg::PH_COMMENT: begin
				if (byte_in == 8'd0) begin
					count_d = 4'd0;
					phase_d = gzhp_pkg::next_section(gzhp_pkg::PH_COMMENT, base_flags);
				end
			end
			gzhp_pkg::PH_HCRC: begin
				if (base_count == 4'd0) begin
					crc_lo_d = byte_in;
					count_d  = 4'd1;
				end else begin
					count_d = 4'd0;
					phase_d = gzhp_pkg::PH_DONE;
					if ({byte_in, base_crc_lo} == ~base_crc[15:0]) begin
						status_d = gzhp_pkg::ST_OK;
					end else begin
						status_d = gzhp_pkg::ST_CRC_BAD;
					end
				end
			end
			default: begin
				phase_d = gzhp_pkg::PH_DONE;
			end
		endcase

		// Running out of sections marks the header complete.
		if (phase_d == gzhp_pkg::PH_DONE && base_phase != gzhp_pkg::PH_DONE
				&& status_d == gzhp_pkg::ST_BUSY) begin
			status_d = gzhp_pkg::ST_OK;
		end
	end

	// Outputs for the byte being consumed.
	always_comb begin
		result.byte_class   = 3'(base_phase);
		result.payload_byte = byte_in;
		result.status       = 3'(status_d);
		result.header_flags = flags_d;
		result.mod_time     = time_d;
		result.extra_flags  = xfl_d;
		result.os_code      = os_d;
		result.running_crc  = ~crc_d[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= gzhp_pkg::PH_FIXED;
			status_q <= gzhp_pkg::ST_BUSY;
			count_q  <= 4'd0;
			flags_q  <= 8'd0;
			time_q   <= 32'd0;
			xfl_q    <= 8'd0;
			os_q     <= 8'd0;
			xleft_q  <= 16'd0;
			crc_q    <= gzhp_pkg::CrcPreset;
			crc_lo_q <= 8'd0;
		end else if (step) begin
			phase_q  <= phase_d;
			status_q <= status_d;
			count_q  <= count_d;
			flags_q  <= flags_d;
			time_q   <= time_d;
			xfl_q    <= xfl_d;
			os_q     <= os_d;
			xleft_q  <= xleft_d;
			crc_q    <= crc_d;
			crc_lo_q <= crc_lo_d;
		end
	end

	// A finished or failed header always carries a final status.
	a_done_has_status: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == gzhp_pkg::PH_DONE |-> status_q != gzhp_pkg::ST_BUSY)
		else $error("done phase with busy status");

	// The fixed header position never runs past its ten bytes.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q < gzhp_pkg::FixedLen)
		else $error("byte counter out of range");

	// Two-byte sections only ever count to one.
	a_pair_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == gzhp_pkg::PH_XLEN || phase_q == gzhp_pkg::PH_HCRC) |-> count_q <= 4'd1)
		else $error("pair counter out of range");

endmodule
